@@ design/ray_box_slab_test_core_macros.svh @@
// Assertion macros used by the checker file of the ray/box slab test core.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef RAY_BOX_SLAB_TEST_CORE_MACROS_SVH
`define RAY_BOX_SLAB_TEST_CORE_MACROS_SVH

// Same-cycle implication.
`define RBST_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RBST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/rbst_pkg.sv @@
// Package for the ray/box slab test core: widths, codes, lane structs and
// the saturating sign/magnitude helper. No dependencies.
package rbst_pkg;

  localparam int COORD_W   = 32;
  localparam int FRAC_BITS = 16;
  localparam int NUM_LANES = 3;
  // |corner - origin| needs one more bit than a coordinate
  localparam int MAG_W     = COORD_W + 1;
  localparam int PROD_W    = MAG_W + COORD_W;
  localparam int SAT_W     = PROD_W - FRAC_BITS;
  // quotient bits of 2^(2*FRAC_BITS) / |d|
  localparam int DIV_STEPS = 2 * FRAC_BITS + 1;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  typedef logic signed [COORD_W-1:0] coord_t;

  localparam coord_t COORD_MAXPOS = {1'b0, {(COORD_W-1){1'b1}}};
  localparam coord_t COORD_MINNEG = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic [SAT_W-1:0] SAT_MAXPOS = (SAT_W'(1) << (COORD_W-1)) - SAT_W'(1);
  localparam logic [SAT_W-1:0] SAT_NEGLIM = SAT_W'(1) << (COORD_W-1);

  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_TEST = 1'b1
  } action_t;

  typedef struct packed {
    logic load;
    logic test;
    logic mul;
    logic sat;
  } lane_ctrl_t;

  typedef struct packed {
    logic   div_busy;
    coord_t t_entry;
    coord_t t_exit;
  } lane_stat_t;

  // Apply sign to a magnitude and clamp to the signed coordinate range.
  function automatic coord_t sat_mag(input logic neg, input logic [SAT_W-1:0] mag);
    if (!neg) begin
      return (mag > SAT_MAXPOS) ? COORD_MAXPOS : coord_t'(mag[COORD_W-1:0]);
    end else if (mag > SAT_NEGLIM) begin
      return COORD_MINNEG;
    end else begin
      return coord_t'(COORD_W'(0) - mag[COORD_W-1:0]);
    end
  endfunction

endpackage

@@ design/rbst_if.sv @@
// Valid/ready channel interfaces of the ray/box slab test core.
// Depends on rbst_pkg for the coordinate type.
interface rbst_in_if import rbst_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   action;
  coord_t vec_a_x;
  coord_t vec_a_y;
  coord_t vec_a_z;
  coord_t vec_b_x;
  coord_t vec_b_y;
  coord_t vec_b_z;
  coord_t t_lo;
  coord_t t_hi;

  modport source (output valid, action, vec_a_x, vec_a_y, vec_a_z,
                  vec_b_x, vec_b_y, vec_b_z, t_lo, t_hi, input ready);
  modport sink   (input valid, action, vec_a_x, vec_a_y, vec_a_z,
                  vec_b_x, vec_b_y, vec_b_z, t_lo, t_hi, output ready);
endinterface

interface rbst_out_if ();
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, hit, input ready);
  modport sink   (input valid, hit, output ready);
endinterface

@@ design/ray_box_slab_test_core.sv @@
// Ray versus axis-aligned box slab test, signed Q16.16.
// Channels: in_ch (sink) carries action, two corner/ray vectors and t_lo/t_hi;
// out_ch (source) carries hit. A word moves when valid and ready are high.
// A load word (action 0) stores the origin and starts three lane dividers that
// form 2^32/|d| one quotient bit per cycle; it produces no output word. The
// 33-step divider sets its cost: in_ch.ready stays low after a load is taken
// until all three dividers are done, so no word is taken while they run.
// A test word (action 1) runs subtract, multiply, saturate/sort in the three
// lanes, then the merge stage; the hit word is loaded into the output register
// and in_ch.ready comes back at the same time, so a new word is taken only
// after the last one is through the lanes. One word is in flight.
// The result sits in an output register: if out_ch stalls, the next word is
// still accepted and processed, and only its final step waits for the register.
// Synchronous active-low reset clears the stored ray to zero (a test before
// any load gives hit 0), empties the output register and idles the core.
// Depends on rbst_pkg, rbst_if, rbst_lane, rbst_merge.
module ray_box_slab_test_core import rbst_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  rbst_in_if.sink   in_ch,
  rbst_out_if.source out_ch
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_SAT,
    ST_OUT
  } state_t;

  state_t               state_r;
  logic                 out_valid_r;
  logic                 out_hit_r;
  coord_t               t_lo_r;
  coord_t               t_hi_r;

  logic                 in_fire;
  logic                 out_load;
  lane_ctrl_t           ctrl;
  coord_t               lane_a [NUM_LANES];
  coord_t               lane_b [NUM_LANES];
  lane_stat_t           lane_stat [NUM_LANES];
  logic [NUM_LANES-1:0] lane_busy;
  logic                 merge_hit;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.hit   = out_hit_r;

  // final step may fill the output register once the previous word is claimed
  assign out_load = (state_r == ST_OUT) && (!out_valid_r || out_ch.ready);

  assign ctrl.load = in_fire && (in_ch.action == ACT_LOAD);
  assign ctrl.test = in_fire && (in_ch.action == ACT_TEST);
  assign ctrl.mul  = (state_r == ST_MUL);
  assign ctrl.sat  = (state_r == ST_SAT);

  assign lane_a[0] = in_ch.vec_a_x;
  assign lane_a[1] = in_ch.vec_a_y;
  assign lane_a[2] = in_ch.vec_a_z;
  assign lane_b[0] = in_ch.vec_b_x;
  assign lane_b[1] = in_ch.vec_b_y;
  assign lane_b[2] = in_ch.vec_b_z;

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    rbst_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .ctrl  (ctrl),
      .vec_a (lane_a[g]),
      .vec_b (lane_b[g]),
      .stat  (lane_stat[g])
    );
    assign lane_busy[g] = lane_stat[g].div_busy;
  end

  rbst_merge u_merge (
    .lane_stat (lane_stat),
    .t_lo      (t_lo_r),
    .t_hi      (t_hi_r),
    .hit       (merge_hit)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
        out_hit_r   <= merge_hit;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            t_lo_r  <= in_ch.t_lo;
            t_hi_r  <= in_ch.t_hi;
            state_r <= (in_ch.action == ACT_TEST) ? ST_MUL : ST_DIV;
          end
        end
        ST_DIV: begin
          if (!(|lane_busy)) state_r <= ST_IDLE;
        end
        ST_MUL: state_r <= ST_SAT;
        ST_SAT: state_r <= ST_OUT;
        ST_OUT: begin
          // wait here only while the previous word is still unclaimed
          if (out_load) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ design/rbst_lane.sv @@
// One axis lane: holds origin and reciprocal, runs a bit-serial restoring
// divider on ray load and the slab product/saturate/sort on box test. Uses rbst_pkg.
module rbst_lane import rbst_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  lane_ctrl_t ctrl,
  input  coord_t     vec_a,
  input  coord_t     vec_b,
  output lane_stat_t stat
);

  coord_t                 origin_r;
  coord_t                 inv_r;
  logic                   div_busy_r;
  logic [DIV_CNT_W-1:0]   div_cnt_r;
  logic [COORD_W-1:0]     div_den_r;
  logic [COORD_W-1:0]     div_rem_r;
  logic [DIV_STEPS-1:0]   div_quo_r;
  logic                   div_neg_r;

  logic [MAG_W-1:0]       mag_a_r;
  logic [MAG_W-1:0]       mag_b_r;
  logic                   neg_a_r;
  logic                   neg_b_r;
  logic [COORD_W-1:0]     imag_r;
  logic [PROD_W-1:0]      prod_a_r;
  logic [PROD_W-1:0]      prod_b_r;
  coord_t                 entry_r;
  coord_t                 exit_r;

  logic                   d_neg;
  logic [COORD_W-1:0]     d_mag;
  logic                   num_bit;
  logic [MAG_W-1:0]       trial;
  logic [MAG_W-1:0]       trial_sub;
  logic                   trial_ge;
  logic [COORD_W-1:0]     rem_nxt;
  logic [DIV_STEPS-1:0]   quo_nxt;
  logic [MAG_W-1:0]       diff_a;
  logic [MAG_W-1:0]       diff_b;
  logic [MAG_W-1:0]       dmag_a;
  logic [MAG_W-1:0]       dmag_b;
  logic                   i_neg;
  logic [COORD_W-1:0]     i_mag;
  coord_t                 t_a;
  coord_t                 t_b;

  // Divider: numerator is a single one at bit DIV_STEPS-1. A zero divisor
  // yields an all-ones quotient, which saturates to the largest positive value.
  always_comb begin
    d_neg     = vec_b[COORD_W-1];
    d_mag     = d_neg ? (COORD_W'(0) - vec_b) : vec_b;
    num_bit   = (div_cnt_r == DIV_CNT_W'(DIV_STEPS));
    trial     = {div_rem_r, num_bit};
    trial_sub = trial - {1'b0, div_den_r};
    trial_ge  = (trial >= {1'b0, div_den_r});
    rem_nxt   = trial_ge ? trial_sub[COORD_W-1:0] : trial[COORD_W-1:0];
    quo_nxt   = {div_quo_r[DIV_STEPS-2:0], trial_ge};
  end

  always_comb begin
    diff_a = {vec_a[COORD_W-1], vec_a} - {origin_r[COORD_W-1], origin_r};
    diff_b = {vec_b[COORD_W-1], vec_b} - {origin_r[COORD_W-1], origin_r};
    dmag_a = diff_a[MAG_W-1] ? (MAG_W'(0) - diff_a) : diff_a;
    dmag_b = diff_b[MAG_W-1] ? (MAG_W'(0) - diff_b) : diff_b;
    i_neg  = inv_r[COORD_W-1];
    i_mag  = i_neg ? (COORD_W'(0) - inv_r) : inv_r;
    t_a    = sat_mag(neg_a_r, prod_a_r[PROD_W-1:FRAC_BITS]);
    t_b    = sat_mag(neg_b_r, prod_b_r[PROD_W-1:FRAC_BITS]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_r   <= '0;
      inv_r      <= '0;
      div_busy_r <= 1'b0;
      div_cnt_r  <= '0;
    end else if (ctrl.load) begin
      origin_r   <= vec_a;
      div_busy_r <= 1'b1;
      div_cnt_r  <= DIV_CNT_W'(DIV_STEPS);
    end else if (div_busy_r) begin
      div_cnt_r <= div_cnt_r - DIV_CNT_W'(1);
      if (div_cnt_r == DIV_CNT_W'(1)) begin
        div_busy_r <= 1'b0;
        inv_r      <= sat_mag(div_neg_r, SAT_W'(quo_nxt));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      div_den_r <= d_mag;
      div_neg_r <= d_neg;
      div_rem_r <= '0;
      div_quo_r <= '0;
    end else if (div_busy_r) begin
      div_rem_r <= rem_nxt;
      div_quo_r <= quo_nxt;
    end
    if (ctrl.test) begin
      mag_a_r <= dmag_a;
      mag_b_r <= dmag_b;
      neg_a_r <= diff_a[MAG_W-1] ^ i_neg;
      neg_b_r <= diff_b[MAG_W-1] ^ i_neg;
      imag_r  <= i_mag;
    end
    if (ctrl.mul) begin
      prod_a_r <= mag_a_r * imag_r;
      prod_b_r <= mag_b_r * imag_r;
    end
    if (ctrl.sat) begin
      entry_r <= (t_a < t_b) ? t_a : t_b;
      exit_r  <= (t_a < t_b) ? t_b : t_a;
    end
  end

  assign stat.div_busy = div_busy_r;
  assign stat.t_entry  = entry_r;
  assign stat.t_exit   = exit_r;

endmodule

@@ design/rbst_merge.sv @@
// Merge stage: narrows the test interval by the per-lane entries and exits
// and forms the hit flag. Uses rbst_pkg.
module rbst_merge import rbst_pkg::*; (
  input  lane_stat_t lane_stat [NUM_LANES],
  input  coord_t     t_lo,
  input  coord_t     t_hi,
  output logic       hit
);

  coord_t lo;
  coord_t hi;

  always_comb begin
    lo = t_lo;
    hi = t_hi;
    for (int i = 0; i < NUM_LANES; i++) begin
      if (coord_t'(lane_stat[i].t_entry) > lo) lo = lane_stat[i].t_entry;
      if (coord_t'(lane_stat[i].t_exit) < hi) hi = lane_stat[i].t_exit;
    end
    hit = (lo < hi);
  end

endmodule

@@ design/rbst_checker.sv @@
// Port-level checker for the ray/box slab test core, bound to the top level.
// Depends on rbst_pkg and ray_box_slab_test_core_macros.svh.
`include "ray_box_slab_test_core_macros.svh"

module rbst_checker import rbst_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_action,
  input logic out_valid,
  input logic out_ready,
  input logic out_hit
);

  logic out_stall;
  logic test_fire;
  logic load_fire;

  assign out_stall = out_valid && !out_ready;
  assign test_fire = in_valid && in_ready && (in_action == ACT_TEST);
  assign load_fire = in_valid && in_ready && (in_action == ACT_LOAD);

  `RBST_ASSERT_NEXT(a_out_hold, out_stall, out_valid, "stalled output word dropped")
  `RBST_ASSERT_NEXT(a_out_stable, out_stall, $stable(out_hit), "stalled hit changed")
  `RBST_ASSERT_NEXT(a_test_latency, test_fire && !out_valid, ##3 out_valid, "test result late")
  `RBST_ASSERT_NEXT(a_load_stall, load_fire, ##32 !in_ready, "input taken during reciprocal")

endmodule

bind ray_box_slab_test_core rbst_checker u_rbst_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_action (in_ch.action),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_hit   (out_ch.hit)
);
